// ===== rtl/cds_pkg.sv =====
// Shared types, status codes and month tables for the calendar date step block.
package cds_pkg;

  typedef logic [4:0]  day_t;
  typedef logic [3:0]  month_t;
  typedef logic [13:0] year_t;
  typedef logic [8:0]  doy_t;
  typedef logic [1:0]  status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_BAD_FIELD = 2'd1;
  localparam status_t ST_BAD_LEN   = 2'd2;
  localparam status_t ST_BAD_YEAR  = 2'd3;

  localparam year_t  YEAR_MAX = 14'd16383;
  localparam month_t MON_JAN  = 4'd1;
  localparam month_t MON_FEB  = 4'd2;
  localparam month_t MON_MAR  = 4'd3;
  localparam month_t MON_DEC  = 4'd12;
  localparam day_t   DAY_LAST_DEC = 5'd31;

  // Month length in a common year; zero for codes that are not months.
  function automatic day_t month_len_nl(input month_t m);
    day_t len;
    begin
      case (m)
        4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
        4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
        4'd2:                                       len = 5'd28;
        default:                                    len = 5'd0;
      endcase
      return len;
    end
  endfunction

  // Days of a common year that come before the first of the month.
  function automatic doy_t cum_before_nl(input month_t m);
    doy_t cum;
    begin
      case (m)
        4'd1:    cum = 9'd0;
        4'd2:    cum = 9'd31;
        4'd3:    cum = 9'd59;
        4'd4:    cum = 9'd90;
        4'd5:    cum = 9'd120;
        4'd6:    cum = 9'd151;
        4'd7:    cum = 9'd181;
        4'd8:    cum = 9'd212;
        4'd9:    cum = 9'd243;
        4'd10:   cum = 9'd273;
        4'd11:   cum = 9'd304;
        4'd12:   cum = 9'd334;
        default: cum = 9'd0;
      endcase
      return cum;
    end
  endfunction

endpackage

// ===== rtl/cds_leap.sv =====
// Two-stage leap-year unit: divide by 25 via reciprocal multiply, then the 4/100/400 rule.
module cds_leap (
  input  logic          clk,
  input  cds_pkg::year_t year_i,
  output logic          leap_o
);
  import cds_pkg::*;

  // floor(y / 25) == (y * 5243) >> 17 for every 14-bit y
  localparam int RecipShift = 17;
  localparam logic [12:0] Recip25 = 13'd5243;
  localparam int ProdW = 27;

  logic [ProdW-1:0] prod_r;
  year_t            year_r;
  logic             leap_r;
  logic [ProdW-1:0] prod_nxt;
  logic [9:0]       quot;
  year_t            quot_x25;
  year_t            rem25;
  logic             leap_nxt;

  assign prod_nxt = ProdW'(year_i) * ProdW'(Recip25);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    year_r <= year_i;
    leap_r <= leap_nxt;
  end

  always_comb begin
    quot     = prod_r[RecipShift +: 10];
    quot_x25 = 14'({quot, 4'b0}) + 14'({quot, 3'b0}) + 14'(quot);
    rem25    = year_r - quot_x25;
    // divisible by 100 means by 4 and 25; by 400 means by 16 and 25
    leap_nxt = (year_r[1:0] == 2'b00) && ((rem25 != '0) || (year_r[3:0] == 4'b0000));
  end

  assign leap_o = leap_r;

endmodule

// ===== rtl/calendar_date_step.sv =====
// Calendar date step: for one Gregorian date per beat, returns leap flag,
// previous date, next date and ordinal day of the year.
//
// Input channel: a beat is taken at a rising edge with start high and busy
// low. busy stays low, so a new date may be offered every cycle.
// Result channel: out_valid marks each result for exactly one cycle; the
// receiver takes it at the edge that ends that cycle and cannot stall.
// The result passes three register stages (input capture with the
// divide-by-25 product, leap flag and month tables, result assembly).
// Throughput: one date per cycle; every stage takes a new beat each cycle.
// A nonzero out_status (bad day or month, day past month length, year at a
// range end) comes with every other result field zero.
// Reset (rst_n low, synchronous) clears the stage valid bits; dates in
// flight are dropped and no result appears for them.
module calendar_date_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  cds_pkg::day_t    in_day,
  input  cds_pkg::month_t  in_month,
  input  cds_pkg::year_t   in_year,
  output logic             out_valid,
  output cds_pkg::status_t out_status,
  output logic             out_is_leap,
  output cds_pkg::day_t    out_prev_day,
  output cds_pkg::month_t  out_prev_month,
  output cds_pkg::year_t   out_prev_year,
  output cds_pkg::day_t    out_next_day,
  output cds_pkg::month_t  out_next_month,
  output cds_pkg::year_t   out_next_year,
  output cds_pkg::doy_t    out_day_of_year
);
  import cds_pkg::*;

  // stage 1: captured beat
  logic    v1_r;
  day_t    d1_r;
  month_t  m1_r;
  year_t   y1_r;
  logic    bad1_r;
  // stage 2: table lookups, leap flag lines up here
  logic    v2_r;
  day_t    d2_r;
  month_t  m2_r;
  year_t   y2_r;
  logic    bad2_r;
  day_t    mlen2_r;
  day_t    plen2_r;
  doy_t    cum2_r;
  logic    leap2;
  // stage 3: results
  logic    v3_r;
  status_t st3_r;
  logic    leap3_r;
  day_t    pd3_r, nd3_r;
  month_t  pm3_r, nm3_r;
  year_t   py3_r, ny3_r;
  doy_t    doy3_r;

  status_t st_nxt;
  logic    leap_feb;
  day_t    lim;
  day_t    plen;
  day_t    pd_nxt, nd_nxt;
  month_t  pm_nxt, nm_nxt;
  year_t   py_nxt, ny_nxt;
  doy_t    doy_nxt;

  assign busy = 1'b0;

  cds_leap u_leap (
    .clk    (clk),
    .year_i (in_year),
    .leap_o (leap2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start & ~busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_r    <= in_day;
    m1_r    <= in_month;
    y1_r    <= in_year;
    bad1_r  <= (in_day == '0) || (in_month == '0) || (in_month > MON_DEC);

    d2_r    <= d1_r;
    m2_r    <= m1_r;
    y2_r    <= y1_r;
    bad2_r  <= bad1_r;
    mlen2_r <= month_len_nl(m1_r);
    plen2_r <= month_len_nl(m1_r - 4'd1);
    cum2_r  <= cum_before_nl(m1_r);

    st3_r   <= st_nxt;
    leap3_r <= (st_nxt == ST_OK) ? leap2 : 1'b0;
    pd3_r   <= pd_nxt;
    pm3_r   <= pm_nxt;
    py3_r   <= py_nxt;
    nd3_r   <= nd_nxt;
    nm3_r   <= nm_nxt;
    ny3_r   <= ny_nxt;
    doy3_r  <= doy_nxt;
  end

  always_comb begin
    leap_feb = leap2 && (m2_r == MON_FEB);
    lim      = mlen2_r + 5'(leap_feb);
    // previous month is February only when this one is March
    plen     = plen2_r + 5'(leap2 && (m2_r == MON_MAR));

    if (bad2_r)                                   st_nxt = ST_BAD_FIELD;
    else if (d2_r > lim)                          st_nxt = ST_BAD_LEN;
    else if ((y2_r == '0) || (y2_r == YEAR_MAX))  st_nxt = ST_BAD_YEAR;
    else                                          st_nxt = ST_OK;

    pd_nxt = d2_r - 5'd1;
    pm_nxt = m2_r;
    py_nxt = y2_r;
    if (d2_r == 5'd1) begin
      if (m2_r == MON_JAN) begin
        pd_nxt = DAY_LAST_DEC;
        pm_nxt = MON_DEC;
        py_nxt = y2_r - 14'd1;
      end else begin
        pd_nxt = plen;
        pm_nxt = m2_r - 4'd1;
      end
    end

    nd_nxt = d2_r + 5'd1;
    nm_nxt = m2_r;
    ny_nxt = y2_r;
    if (d2_r >= lim) begin
      nd_nxt = 5'd1;
      if (m2_r == MON_DEC) begin
        nm_nxt = MON_JAN;
        ny_nxt = y2_r + 14'd1;
      end else begin
        nm_nxt = m2_r + 4'd1;
      end
    end

    doy_nxt = cum2_r + 9'(d2_r) + 9'(leap2 && (m2_r > MON_FEB));

    // drop all fields on an error
    if (st_nxt != ST_OK) begin
      pd_nxt  = '0;
      pm_nxt  = '0;
      py_nxt  = '0;
      nd_nxt  = '0;
      nm_nxt  = '0;
      ny_nxt  = '0;
      doy_nxt = '0;
    end
  end

  assign out_valid       = v3_r;
  assign out_status      = st3_r;
  assign out_is_leap     = leap3_r;
  assign out_prev_day    = pd3_r;
  assign out_prev_month  = pm3_r;
  assign out_prev_year   = py3_r;
  assign out_next_day    = nd3_r;
  assign out_next_month  = nm3_r;
  assign out_next_year   = ny3_r;
  assign out_day_of_year = doy3_r;

endmodule
